>>> rtl/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

	// Field and register widths
	localparam int PIX_W      = 8;
	localparam int TAP_W      = 8;
	localparam int NUM_TAPS   = 4;
	localparam int W_REG_W    = 11;
	localparam int H_REG_W    = 13;
	localparam int R_REG_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_W      = 12;
	localparam int HEIGHT_LIMIT = 4096;

	// Arithmetic widths: tap sum <= 255*7, weighted sum <= 255 * tap sum
	localparam int TS_W   = 11;
	localparam int ACC_W  = 19;
	localparam int QUOT_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_CENTER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_DIST1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_DIST2     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_DIST3     = 3'd6;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ROW,
		ST_RDIV,
		ST_CLOAD,
		ST_CSUM,
		ST_CDIV,
		ST_FIN
	} state_t;

endpackage

>>> rtl/ssc_ram.sv
`timescale 1ns / 1ps

module ssc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ssc_cell.sv
`timescale 1ns / 1ps

module ssc_cell
	import ssc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic [PIX_W-1:0] pix_in,
	input  logic [TAP_W-1:0] weight,
	input  logic [ACC_W-1:0] psum_in,
	output logic [PIX_W-1:0] pix,
	output logic [ACC_W-1:0] psum
);

	logic [PIX_W+TAP_W-1:0] prod_q;

	// Hold one sample, hand it on to the next cell on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix <= '0;
		end else if (shift_en) begin
			pix <= pix_in;
		end
	end

	// Weight the sample, then add into the partial sum from the previous cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			psum   <= '0;
		end else begin
			prod_q <= pix * weight;
			psum   <= psum_in + ACC_W'(prod_q);
		end
	end

endmodule

>>> rtl/ssc_div.sv
`timescale 1ns / 1ps

module ssc_div
	import ssc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  dividend,
	input  logic [TS_W-1:0]   divisor,
	output logic [QUOT_W-1:0] quot,
	output logic              done
);

	logic [ACC_W-1:0]          rem_q;
	logic [ACC_W-1:0]          dsh_q;
	logic [$clog2(QUOT_W)-1:0] cnt_q;
	logic                      run_q;

	// Restoring division, one quotient bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done  <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (32'(cnt_q) == QUOT_W - 1) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= ACC_W'(divisor) << (QUOT_W - 1);
			quot  <= '0;
		end else if (run_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quot  <= {quot[QUOT_W-2:0], 1'b1};
			end else begin
				quot  <= {quot[QUOT_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

>>> rtl/separable_symmetric_convolution.sv
`timescale 1ns / 1ps

// Separable symmetric 2-D FIR on a raster stream of 8-bit grey pixels. Each
// pixel is filtered along its row and then down its column with a kernel of
// 2*R+1 taps, dividing by the tap sum after each pass; pixels within R of
// an edge leave unchanged. Results trail the input by R rows plus R pixels;
// flush beats drain the tail of a frame. One beat is handled at a time: a
// pixel runs the row pass through the cell chain and a division, and when a
// column result is produced it also reads 2*R+1 line buffer entries into the
// 2*MAX_RADIUS+1 cell column chain and divides again; a beat that only
// releases a border pixel skips both passes. A stalled output holds the
// sequencer until the pending beat leaves. A configuration write to a known
// register clears the position counters and drops pending results.
module separable_symmetric_convolution
	import ssc_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  frame_done
);

	localparam int WIN        = 2 * MAX_RADIUS + 1;
	localparam int LINES      = WIN;
	localparam int LINE_W     = $clog2(LINES);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
	localparam int R_W        = $clog2(MAX_RADIUS + 1);
	localparam int RAW_DEPTH  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
	localparam int WP_W       = $clog2(RAW_DEPTH);
	localparam int PEND_W     = $clog2(RAW_DEPTH + 1);
	localparam int FPOS_W     = $clog2(MAX_WIDTH * HEIGHT_LIMIT);
	localparam int LRAM_DEPTH = LINES * MAX_WIDTH;
	localparam int LA_W       = $clog2(LRAM_DEPTH);
	localparam int STEP_W     = $clog2(WIN + 2);

	state_t state_q, state_d;

	logic [W_REG_W-1:0] cfg_w_q;
	logic [H_REG_W-1:0] cfg_h_q;
	logic [R_REG_W-1:0] cfg_r_q;
	logic [TAP_W-1:0]   tap_q [NUM_TAPS];

	logic [WEFF_W-1:0]  w_eff;
	logic [H_REG_W-1:0] h_eff;
	logic [R_W-1:0]     r_eff;
	logic [TS_W-1:0]    tap_sum;
	logic [PEND_W-1:0]  dly;
	logic [TAP_W-1:0]   wt [WIN];

	logic [COL_W-1:0]  col_q, col_pre_q;
	logic [ROW_W-1:0]  row_q, row_pre_q;
	logic [LINE_W-1:0] line_q, line_pre_q;
	logic [FPOS_W-1:0] fpos_q;
	logic [WP_W-1:0]   wp_q;
	logic [PEND_W-1:0] pend_q;
	logic              is_pix_q;
	logic              emit_q, inner_q, fdone_q;
	logic              rd_pend_q;
	logic [STEP_W-1:0] step_q;

	logic              in_acc, pix_acc;
	logic              emit_now, inner_now, fdone_now, need_row;
	logic              step_clr, div_start, lram_we, lram_re, raw_re, out_load;
	logic [WP_W-1:0]   raw_raddr;
	logic [PIX_W-1:0]  raw_rdata;
	logic [LA_W-1:0]   lram_waddr, lram_raddr;
	logic [PIX_W-1:0]  lram_rdata;
	logic [ACC_W-1:0]  div_dividend;
	logic [QUOT_W-1:0] div_quot;
	logic              div_done;

	logic [PIX_W-1:0] row_pix  [WIN];
	logic [ACC_W-1:0] row_psum [WIN];
	logic [PIX_W-1:0] col_pix  [WIN];
	logic [ACC_W-1:0] col_psum [WIN];

	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              frame_done_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign pix_acc    = in_acc && !req_type;
	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_done = frame_done_q;

	// Clamp the configuration into its working range
	always_comb begin
		if (cfg_w_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (32'(cfg_w_q) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			h_eff = H_REG_W'(1);
		end else if (32'(cfg_h_q) > HEIGHT_LIMIT) begin
			h_eff = H_REG_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = cfg_h_q;
		end
		if (32'(cfg_r_q) > MAX_RADIUS) begin
			r_eff = R_W'(MAX_RADIUS);
		end else begin
			r_eff = R_W'(cfg_r_q);
		end
		dly = PEND_W'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
	end

	// Tap sum over the active taps
	always_comb begin
		tap_sum = TS_W'(tap_q[0]);
		for (int i = 1; i < NUM_TAPS; i++) begin
			if (i <= 32'(r_eff)) begin
				tap_sum = tap_sum + (TS_W'(tap_q[i]) << 1);
			end
		end
	end

	// Cell weights: tap by distance from the center cell, zero past the kernel
	always_comb begin
		int tap_ofs;
		for (int k = 0; k < WIN; k++) begin
			tap_ofs = (k >= 32'(r_eff)) ? k - 32'(r_eff) : 32'(r_eff) - k;
			if (k <= 2 * 32'(r_eff) && tap_ofs < NUM_TAPS) begin
				wt[k] = tap_q[tap_ofs[1:0]];
			end else begin
				wt[k] = '0;
			end
		end
	end

	// Row pass: chain of cells over the last raw pixels
	for (genvar k = 0; k < WIN; k++) begin : g_row
		if (k == 0) begin : g_head
			ssc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(pix_acc),
				.pix_in  (pixel_in),
				.weight  (wt[k]),
				.psum_in ('0),
				.pix     (row_pix[k]),
				.psum    (row_psum[k])
			);
		end else begin : g_body
			ssc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(pix_acc),
				.pix_in  (row_pix[k-1]),
				.weight  (wt[k]),
				.psum_in (row_psum[k-1]),
				.pix     (row_pix[k]),
				.psum    (row_psum[k])
			);
		end
	end

	// Column pass: chain of cells loaded from the line buffer
	for (genvar k = 0; k < WIN; k++) begin : g_col
		if (k == 0) begin : g_head
			ssc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(rd_pend_q),
				.pix_in  (lram_rdata),
				.weight  (wt[k]),
				.psum_in ('0),
				.pix     (col_pix[k]),
				.psum    (col_psum[k])
			);
		end else begin : g_body
			ssc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(rd_pend_q),
				.pix_in  (col_pix[k-1]),
				.weight  (wt[k]),
				.psum_in (col_psum[k-1]),
				.pix     (col_pix[k]),
				.psum    (col_psum[k])
			);
		end
	end

	// Decide on the oldest pending pixel
	always_comb begin
		int ra;
		emit_now  = (pend_q != '0) &&
			((32'(pend_q) > 32'(fpos_q)) || (pend_q > dly));
		fdone_now = (32'(pend_q) == 32'(fpos_q) + 1);
		inner_now = is_pix_q && (32'(pend_q) == 32'(dly) + 1) && (tap_sum != '0) &&
			(32'(col_pre_q) >= 2 * 32'(r_eff)) && (32'(row_pre_q) >= 2 * 32'(r_eff));
		need_row  = is_pix_q && (tap_sum != '0) && (32'(col_pre_q) >= 2 * 32'(r_eff));
		ra = int'(wp_q) - int'(pend_q);
		if (ra < 0) begin
			ra = ra + RAW_DEPTH;
		end
		raw_raddr = WP_W'(ra);
	end

	// Line buffer addresses
	always_comb begin
		int ln;
		ln = int'(line_pre_q) - int'(step_q);
		if (ln < 0) begin
			ln = ln + LINES;
		end
		lram_waddr = LA_W'(32'(line_pre_q) * MAX_WIDTH + 32'(col_pre_q) - 32'(r_eff));
		lram_raddr = LA_W'(ln * MAX_WIDTH + 32'(col_pre_q) - 32'(r_eff));
	end

	assign div_dividend = (state_q == ST_CSUM) ? col_psum[WIN-1] : row_psum[WIN-1];

	// Sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		step_clr  = 1'b0;
		div_start = 1'b0;
		lram_we   = 1'b0;
		lram_re   = 1'b0;
		raw_re    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				step_clr = 1'b1;
				raw_re   = emit_now;
				if (need_row) begin
					state_d = ST_ROW;
				end else if (emit_now) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROW: begin
				if (32'(step_q) == WIN) begin
					div_start = 1'b1;
					state_d   = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (div_done) begin
					lram_we  = 1'b1;
					step_clr = 1'b1;
					if (inner_q) begin
						state_d = ST_CLOAD;
					end else if (emit_q) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLOAD: begin
				lram_re = (32'(step_q) <= 2 * 32'(r_eff));
				if (32'(step_q) == 2 * 32'(r_eff) + 1) begin
					step_clr = 1'b1;
					state_d  = ST_CSUM;
				end
			end
			ST_CSUM: begin
				if (32'(step_q) == WIN + 1) begin
					div_start = 1'b1;
					state_d   = ST_CDIV;
				end
			end
			ST_CDIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step counter and line buffer read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			step_q    <= step_clr ? '0 : step_q + 1'b1;
			rd_pend_q <= lram_re;
		end
	end

	// Configuration registers, position counters and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= W_REG_W'(640);
			cfg_h_q  <= H_REG_W'(480);
			cfg_r_q  <= R_REG_W'(1);
			tap_q[0] <= TAP_W'(2);
			tap_q[1] <= TAP_W'(1);
			tap_q[2] <= '0;
			tap_q[3] <= '0;
			col_q    <= '0;
			row_q    <= '0;
			line_q   <= '0;
			fpos_q   <= '0;
			wp_q     <= '0;
			pend_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_w_q  <= cfg_data[W_REG_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_h_q  <= cfg_data[H_REG_W-1:0];
				REG_KERNEL_RADIUS: cfg_r_q  <= cfg_data[R_REG_W-1:0];
				REG_TAP_CENTER:    tap_q[0] <= cfg_data[TAP_W-1:0];
				REG_TAP_DIST1:     tap_q[1] <= cfg_data[TAP_W-1:0];
				REG_TAP_DIST2:     tap_q[2] <= cfg_data[TAP_W-1:0];
				REG_TAP_DIST3:     tap_q[3] <= cfg_data[TAP_W-1:0];
				default: ;
			endcase
			// Restart the stream on any known register
			if (cfg_index <= REG_TAP_DIST3) begin
				col_q  <= '0;
				row_q  <= '0;
				line_q <= '0;
				fpos_q <= '0;
				pend_q <= '0;
			end
		end else if (pix_acc) begin
			// Advance the raster position
			if (32'(col_q) + 1 >= 32'(w_eff)) begin
				col_q <= '0;
				if (32'(row_q) + 1 >= 32'(h_eff)) begin
					row_q  <= '0;
					line_q <= '0;
					fpos_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					line_q <= (32'(line_q) + 1 >= LINES) ? '0 : line_q + 1'b1;
					fpos_q <= fpos_q + 1'b1;
				end
			end else begin
				col_q  <= col_q + 1'b1;
				fpos_q <= fpos_q + 1'b1;
			end
			wp_q <= (32'(wp_q) + 1 >= RAW_DEPTH) ? '0 : wp_q + 1'b1;
			if (32'(pend_q) < RAW_DEPTH) begin
				pend_q <= pend_q + 1'b1;
			end
		end else if (state_q == ST_EVAL && emit_now) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// Capture the beat's position and the emit decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pix_q <= 1'b0;
			emit_q   <= 1'b0;
			inner_q  <= 1'b0;
			fdone_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				is_pix_q <= !req_type;
			end
			if (state_q == ST_EVAL) begin
				emit_q  <= emit_now;
				inner_q <= inner_now;
				fdone_q <= fdone_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_pre_q  <= col_q;
			row_pre_q  <= row_q;
			line_pre_q <= line_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q  <= inner_q ? div_quot : raw_rdata;
			frame_done_q <= fdone_q;
		end
	end

	// Raw pixel ring
	ssc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(RAW_DEPTH)
	) u_raw_ram (
		.clk  (clk),
		.we   (pix_acc),
		.waddr(wp_q),
		.wdata(pixel_in),
		.re   (raw_re),
		.raddr(raw_raddr),
		.rdata(raw_rdata)
	);

	// Row result line buffer
	ssc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(LRAM_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (lram_we),
		.waddr(lram_waddr),
		.wdata(div_quot),
		.re   (lram_re),
		.raddr(lram_raddr),
		.rdata(lram_rdata)
	);

	// Shared divider by the tap sum
	ssc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (tap_sum),
		.quot    (div_quot),
		.done    (div_done)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ssc_pkg::*;

	localparam int LINE_MAX  = 1024;
	localparam int RAD_MAX   = 3;
	localparam int WIN_N     = 2 * RAD_MAX + 1;
	localparam int RAW_N     = RAD_MAX * LINE_MAX + RAD_MAX + 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE    = 150;
	localparam int REG_NONE  = 7;

	typedef struct packed {
		logic             rt;
		logic [PIX_W-1:0] px;
	} pix_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             fd;
	} out_pix_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  req_type;
	logic [PIX_W-1:0]      pixel_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      pixel_out;
	logic                  frame_done;

	separable_symmetric_convolution dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .frame_done(frame_done)
	);

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pix_beat_t beat_q[$];
	out_pix_t  filt_q[$];

	// Shadow of the filter state
	logic [12:0]      shadow_reg[7];
	logic [PIX_W-1:0] raw_ring[RAW_N];
	int               raw_wr;
	logic [PIX_W-1:0] rowbuf[WIN_N * LINE_MAX];
	logic [PIX_W-1:0] win[WIN_N];
	int               col_pos, row_pos, pend_cnt;

	int  errors = 0;
	int  n_in = 0, n_out = 0, n_frames = 0, n_phases = 0;
	int  acc_count = 0, acc_seen = 0;
	int  idle_cycles = 0;
	bit  quiet = 0;
	int  in_gap = 0, stall_left = 0;

	function automatic int eff_w();
		int v;
		v = int'(shadow_reg[REG_IMAGE_WIDTH]);
		if (v == 0) v = 1;
		if (v > LINE_MAX) v = LINE_MAX;
		return v;
	endfunction

	function automatic int eff_h();
		int v;
		v = int'(shadow_reg[REG_IMAGE_HEIGHT]);
		if (v == 0) v = 1;
		if (v > HEIGHT_LIMIT) v = HEIGHT_LIMIT;
		return v;
	endfunction

	function automatic int tapw(int k);
		return (k <= 3) ? int'(shadow_reg[REG_TAP_CENTER + k]) : 0;
	endfunction

	// Shadow register write; restarts position tracking
	function automatic void shadow_write(int idx, int val);
		int widths[7];
		widths = '{11, 13, 2, 8, 8, 8, 8};
		if (idx >= 7) return;
		shadow_reg[idx] = 13'(val & ((1 << widths[idx]) - 1));
		col_pos = 0;
		row_pos = 0;
		pend_cnt = 0;
	endfunction

	// Advance the shadow filter by one beat; returns 1 when a pixel leaves
	function automatic bit filter_beat(input logic rt, input logic [PIX_W-1:0] px,
			output out_pix_t res);
		int w, h, r, s, d, recv, q, ox, oy, f, i, val;
		w = eff_w();
		h = eff_h();
		r = int'(shadow_reg[REG_KERNEL_RADIUS]);
		s = tapw(0);
		for (i = 1; i <= r; i++) s += 2 * tapw(i);
		d = r * w + r;
		res = '0;
		if (rt == 1'b0) begin
			for (i = WIN_N - 1; i > 0; i--) win[i] = win[i - 1];
			win[0] = px;
			raw_ring[raw_wr] = px;
			raw_wr = (raw_wr + 1) % RAW_N;
			if (s != 0 && col_pos >= 2 * r) begin
				f = tapw(0) * int'(win[r]);
				for (i = 1; i <= r; i++) f += tapw(i) * (int'(win[r - i]) + int'(win[r + i]));
				rowbuf[(row_pos % WIN_N) * LINE_MAX + (col_pos - r)] = 8'(f / s);
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) row_pos = 0;
			end
			if (pend_cnt < RAW_N) pend_cnt++;
		end
		recv = row_pos * w + col_pos;
		if (pend_cnt == 0 || !(pend_cnt > recv || pend_cnt > d)) return 0;
		if (pend_cnt > recv) q = w * h - (pend_cnt - recv);
		else q = recv - pend_cnt;
		ox = q % w;
		oy = q / w;
		val = int'(raw_ring[(raw_wr + RAW_N - pend_cnt) % RAW_N]);
		if (s != 0 && ox >= r && ox + r < w && oy >= r && oy + r < h) begin
			f = tapw(0) * int'(rowbuf[(oy % WIN_N) * LINE_MAX + ox]);
			for (i = 1; i <= r; i++)
				f += tapw(i) * (int'(rowbuf[((oy - i) % WIN_N) * LINE_MAX + ox])
					+ int'(rowbuf[((oy + i) % WIN_N) * LINE_MAX + ox]));
			val = (f / s) & 8'hFF;
		end
		pend_cnt--;
		res.pix = 8'(val);
		res.fd = (q == w * h - 1);
		return 1;
	endfunction

	function automatic int pick_gap();
		int p;
		if (quiet) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive input beats from the pending queue
	always @(negedge clk) begin
		if (arst_n && (!in_valid || acc_count != acc_seen)) begin
			acc_seen = acc_count;
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (beat_q.size() != 0) begin
				in_valid <= 1'b1;
				req_type <= beat_q[0].rt;
				pixel_in <= beat_q[0].px;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output side at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Check output beats, predict on input beats, watch for a hang
	always @(posedge clk) begin : mon
		out_pix_t e;
		out_pix_t p;
		bit       got;
		bit       moved;
		if (arst_n) begin
			moved = 0;
			if (out_valid && !out_stall) begin
				moved = 1;
				n_out++;
				if (filt_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected output pixel %0d frame_done %0b", $realtime,
						pixel_out, frame_done);
				end else begin
					e = filt_q.pop_front();
					if (pixel_out !== e.pix) begin
						errors++;
						$display("%0t: pixel_out expected %0d actual %0d", $realtime,
							e.pix, pixel_out);
					end
					if (frame_done !== e.fd) begin
						errors++;
						$display("%0t: frame_done expected %0b actual %0b", $realtime,
							e.fd, frame_done);
					end
					if (e.fd) n_frames++;
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1;
				n_in++;
				got = filter_beat(req_type, pixel_in, p);
				if (got) filt_q.push_back(p);
				void'(beat_q.pop_front());
				acc_count++;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic cfg_write(int idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= CFG_DATA_W'(val);
		shadow_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every expected pixel has left and the block has settled
	task automatic drain();
		while (beat_q.size() != 0 || filt_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_pix();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 8'd0;
		if (p == 1) return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int rand_tap();
		int p;
		p = $urandom_range(0, 7);
		if (p == 0) return 0;
		if (p == 1) return 255;
		return $urandom_range(0, 255);
	endfunction

	// Program a setting, then stream frames with random drains and flush noise
	task automatic run_phase(int cw, int ch, int cr, int t0, int t1, int t2, int t3,
			int target, int cap);
		int cnt, npx, w, h, d, k, i;
		pix_beat_t b;
		drain();
		cfg_write(REG_IMAGE_WIDTH, cw);
		cfg_write(REG_IMAGE_HEIGHT, ch);
		cfg_write(REG_KERNEL_RADIUS, cr);
		cfg_write(REG_TAP_CENTER, t0);
		cfg_write(REG_TAP_DIST1, t1);
		cfg_write(REG_TAP_DIST2, t2);
		cfg_write(REG_TAP_DIST3, t3);
		n_phases++;
		quiet = (n_phases % 4 == 0);
		w = eff_w();
		h = eff_h();
		d = int'(shadow_reg[REG_KERNEL_RADIUS]) * (w + 1);
		npx = (w * h > cap) ? cap : w * h;
		cnt = 0;
		while (cnt < target) begin
			for (i = 0; i < npx; i++) begin
				b.rt = 1'b0;
				b.px = rand_pix();
				beat_q.push_back(b);
				if ($urandom_range(0, 19) == 0) begin
					b.rt = 1'b1;
					b.px = 8'($urandom_range(0, 255));
					beat_q.push_back(b);
				end
			end
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, d) : d + 2;
			for (i = 0; i < k; i++) begin
				b.rt = 1'b1;
				b.px = 8'($urandom_range(0, 255));
				beat_q.push_back(b);
			end
			cnt += npx + k;
		end
	endtask

	initial begin : stim
		pix_beat_t b;
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		pixel_in = '0;
		out_stall = 1'b0;
		for (i = 0; i < RAW_N; i++) raw_ring[i] = '0;
		for (i = 0; i < WIN_N * LINE_MAX; i++) rowbuf[i] = '0;
		for (i = 0; i < WIN_N; i++) win[i] = '0;
		shadow_reg = '{13'd640, 13'd480, 13'd1, 13'd2, 13'd1, 13'd0, 13'd0};
		raw_wr = 0;
		col_pos = 0;
		row_pos = 0;
		pend_cnt = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: flush before anything, a 4x4 frame of extreme pixels, drain
		cfg_write(REG_NONE, 13'h1FFF);
		cfg_write(REG_IMAGE_WIDTH, 4);
		cfg_write(REG_IMAGE_HEIGHT, 4);
		cfg_write(REG_TAP_CENTER, 255);
		cfg_write(REG_TAP_DIST1, 255);
		b.rt = 1'b1;
		b.px = 8'hFF;
		beat_q.push_back(b);
		for (i = 0; i < 16; i++) begin
			b.rt = 1'b0;
			b.px = (i % 3 == 0) ? 8'd0 : 8'd255;
			beat_q.push_back(b);
		end
		for (i = 0; i < 7; i++) begin
			b.rt = 1'b1;
			b.px = 8'h00;
			beat_q.push_back(b);
		end

		// Fixed corners of the setting space
		run_phase(8, 6, 1, rand_tap(), rand_tap(), rand_tap(), rand_tap(), 100, 600);
		run_phase(10, 8, 2, rand_tap(), rand_tap(), rand_tap(), rand_tap(), 100, 600);
		run_phase(12, 9, 3, 255, 255, 255, 255, 120, 600);
		run_phase(9, 7, 3, 0, 0, 0, 0, 60, 600);
		run_phase(0, 5, 1, 3, 1, 0, 0, 30, 600);
		run_phase(5, 0, 2, 7, 2, 1, 0, 30, 600);
		run_phase(3, 4, 3, 9, 9, 9, 9, 30, 600);
		run_phase(7, 8191, 0, 255, 0, 0, 0, 100, 100);
		run_phase(2047, 1, 0, 200, 100, 0, 0, 200, 200);
		run_phase(6, 6, 2, 0, 255, 0, 0, 60, 600);

		// Random settings, mostly small images
		for (i = 0; i < 4; i++)
			run_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3),
				rand_tap(), rand_tap(), rand_tap(), rand_tap(), 40, 600);

		drain();
		$display("Ran %0d settings: %0d input beats, %0d output beats, %0d frames.",
			n_phases, n_in, n_out, n_frames);
		$display("Covered radii 0..3, zero tap sum, saturated sizes and tiny images.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
